// ===== rtl/min_heap_priority_queue_unit_macros.svh =====
// Assertion helpers for the heap queue unit.
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MHPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("heap queue check failed");

// Next-cycle implication, disabled during reset.
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heap queue check failed");

`endif

// ===== rtl/mhpq_pkg.sv =====
package mhpq_pkg;

   localparam logic FUNC_INSERT  = 1'b0;
   localparam logic FUNC_EXTRACT = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_STEP,
      ST_UP_CMP,
      ST_DN_LOAD,
      ST_DN_STEP,
      ST_DN_CMP,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/min_heap_priority_queue_unit.sv =====
// Channel  Ports                                   Direction  Transfer
// req      req_func, req_value                     in         req_valid & req_ready
// rsp      rsp_min_value, rsp_status, rsp_count    out        rsp_valid & rsp_ready
//
// Insert: UP_STEP/UP_CMP per level climbed; UP_STEP writes directly at the root.
// Extract: DN_LOAD, DN_STEP/DN_CMP per level descended; DN_STEP writes a leaf.
// Each level takes a memory read step and a compare/write step on the heap RAM.
// Errors (full insert, empty extract) go to FINISH, which holds while rsp stalls.
// Synchronous reset empties the heap; RAM contents are not cleared.
// A new request is taken while a finished result waits on rsp.
module min_heap_priority_queue_unit #(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_min_value,
   output logic [1:0]         rsp_status,
   output logic [8:0]         rsp_count
);

   `include "min_heap_priority_queue_unit_macros.svh"

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;

   logic signed [31:0] heap_mem [CAPACITY];

   mhpq_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic signed [31:0]  value_ff, value_in;
   logic signed [31:0]  min_ff, min_in;
   logic [1:0]          status_ff, status_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_min_ff, rsp_min_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [8:0]          rsp_count_ff, rsp_count_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic signed [31:0]  wr_data;
   logic [AW-1:0]       rd_addr_a, rd_addr_b;
   logic signed [31:0]  rd_a_ff, rd_b_ff;

   logic [AW-1:0]       parent;
   logic [XW-1:0]       left, right, count_x;
   logic                left_ok, right_ok, pick_right;
   logic signed [31:0]  pick_val;
   logic [AW-1:0]       pick_idx;
   logic [8:0]          count_ext;

   assign parent     = (pos_ff - 1'b1) >> 1;
   assign left       = {1'b0, pos_ff, 1'b1};
   assign right      = left + 1'b1;
   assign count_x    = XW'(count_in);
   assign left_ok    = left < count_x;
   assign right_ok   = right < count_x;
   assign pick_right = right_ok && (rd_b_ff < rd_a_ff);
   assign pick_val   = pick_right ? rd_b_ff : rd_a_ff;
   assign pick_idx   = pick_right ? right[AW-1:0] : left[AW-1:0];
   assign count_ext  = 9'(count_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      min_in        = min_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = value_ff;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      req_ready     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               min_in    = '0;
               status_in = mhpq_pkg::STATUS_OK;
               if (req_func == mhpq_pkg::FUNC_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = mhpq_pkg::STATUS_FULL;
                     state_in  = mhpq_pkg::ST_FINISH;
                  end else begin
                     value_in = req_value;
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + 1'b1;
                     state_in = mhpq_pkg::ST_UP_STEP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = mhpq_pkg::STATUS_EMPTY;
                     state_in  = mhpq_pkg::ST_FINISH;
                  end else begin
                     rd_addr_b = AW'(count_ff - 1'b1);
                     count_in  = count_ff - 1'b1;
                     state_in  = mhpq_pkg::ST_DN_LOAD;
                  end
               end
            end
         end
         mhpq_pkg::ST_UP_STEP: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = mhpq_pkg::ST_FINISH;
            end else begin
               rd_addr_a = parent;
               state_in  = mhpq_pkg::ST_UP_CMP;
            end
         end
         mhpq_pkg::ST_UP_CMP: begin
            wr_en = 1'b1;
            if (value_ff < rd_a_ff) begin
               wr_data  = rd_a_ff;
               pos_in   = parent;
               state_in = mhpq_pkg::ST_UP_STEP;
            end else begin
               state_in = mhpq_pkg::ST_FINISH;
            end
         end
         mhpq_pkg::ST_DN_LOAD: begin
            min_in   = rd_a_ff;
            value_in = rd_b_ff;
            pos_in   = '0;
            state_in = mhpq_pkg::ST_DN_STEP;
         end
         mhpq_pkg::ST_DN_STEP: begin
            if (!left_ok) begin
               wr_en    = 1'b1;
               state_in = mhpq_pkg::ST_FINISH;
            end else begin
               rd_addr_a = left[AW-1:0];
               rd_addr_b = right_ok ? right[AW-1:0] : left[AW-1:0];
               state_in  = mhpq_pkg::ST_DN_CMP;
            end
         end
         mhpq_pkg::ST_DN_CMP: begin
            wr_en = 1'b1;
            if (pick_val < value_ff) begin
               wr_data  = pick_val;
               pos_in   = pick_idx;
               state_in = mhpq_pkg::ST_DN_STEP;
            end else begin
               state_in = mhpq_pkg::ST_FINISH;
            end
         end
         mhpq_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_min_in    = min_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ext;
               state_in      = mhpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mhpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      min_ff        <= min_in;
      status_ff     <= status_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;

   `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(CAPACITY))
   `MHPQ_ASSERT_NEXT(a_busy_after_transfer, req_valid && req_ready, !req_ready)
   `MHPQ_ASSERT_NOW(a_error_zero_min, rsp_valid && (rsp_status != mhpq_pkg::STATUS_OK),
      rsp_min_value == '0)
   `MHPQ_ASSERT_NEXT(a_insert_count,
      req_valid && req_ready && (req_func == mhpq_pkg::FUNC_INSERT) &&
      (count_ff != CW'(CAPACITY)),
      count_ff == CW'($past(count_ff) + 1'b1))

endmodule

// ===== tb/min_heap_priority_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module min_heap_priority_queue_unit_tb;

   localparam int HEAP_DEPTH = 256;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DIRECTED_ROWS = 25;
   localparam int HOLD_AT_RESPONSE = 120;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_FIRST = 250;
   localparam int QUIET_LAST = 400;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic signed [31:0] min_value;
      logic [1:0]         status;
      logic [8:0]         count;
   } heap_result_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] value;
      bit                 typed;
      heap_result_type    result;
   } heap_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid;
   logic               req_ready;
   logic               req_func;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_min_value;
   logic [1:0]         rsp_status;
   logic [8:0]         rsp_count;

   logic signed [31:0] heap_image [HEAP_DEPTH];
   int                 heap_fill;
   heap_result_type    pending_results [$];

   int items_sent;
   int responses_seen;
   int failures;
   int insert_count;
   int extract_count;
   int full_drops;
   int empty_extracts;
   int peak_fill;
   int cycle_count = 0;
   bit hold_done;

   heap_row_type directed_rows [DIRECTED_ROWS] = '{
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b1,
        '{32'sd0,        mhpq_pkg::STATUS_EMPTY, 9'd0}},
      '{mhpq_pkg::FUNC_INSERT,  32'sh7FFFFFFF, 1'b1,
        '{32'sd0,        mhpq_pkg::STATUS_OK,    9'd1}},
      '{mhpq_pkg::FUNC_INSERT,  32'sh80000000, 1'b1,
        '{32'sd0,        mhpq_pkg::STATUS_OK,    9'd2}},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b1,
        '{32'sh80000000, mhpq_pkg::STATUS_OK,    9'd1}},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sh7FFFFFFF, 1'b1,
        '{32'sh7FFFFFFF, mhpq_pkg::STATUS_OK,    9'd0}},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sh80000000, 1'b1,
        '{32'sd0,        mhpq_pkg::STATUS_EMPTY, 9'd0}},
      '{mhpq_pkg::FUNC_INSERT,  32'sd0,        1'b0, '0},
      '{mhpq_pkg::FUNC_INSERT,  -32'sd1,       1'b0, '0},
      '{mhpq_pkg::FUNC_INSERT,  32'sd5,        1'b0, '0},
      '{mhpq_pkg::FUNC_INSERT,  32'sd5,        1'b0, '0},
      '{mhpq_pkg::FUNC_INSERT,  32'sd5,        1'b0, '0},
      '{mhpq_pkg::FUNC_INSERT,  32'sd3,        1'b0, '0},
      '{mhpq_pkg::FUNC_INSERT,  32'sh7FFFFFFF, 1'b0, '0},
      '{mhpq_pkg::FUNC_INSERT,  32'sh80000000, 1'b0, '0},
      '{mhpq_pkg::FUNC_INSERT,  32'sd1,        1'b0, '0},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b0, '0},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b0, '0},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b0, '0},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b0, '0},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b0, '0},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b0, '0},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b0, '0},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b0, '0},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b0, '0},
      '{mhpq_pkg::FUNC_EXTRACT, 32'sd0,        1'b1,
        '{32'sd0,        mhpq_pkg::STATUS_EMPTY, 9'd0}}
   };

   min_heap_priority_queue_unit #(
      .CAPACITY(HEAP_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_min_value(rsp_min_value),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic heap_result_type heap_apply(logic func, logic signed [31:0] value);
      heap_result_type    r;
      logic signed [31:0] tmp;
      int                 pos;
      int                 parent;
      int                 left;
      int                 pick;
      r = '0;
      if (func == mhpq_pkg::FUNC_INSERT) begin
         if (heap_fill >= HEAP_DEPTH) begin
            r.status = mhpq_pkg::STATUS_FULL;
         end else begin
            pos = heap_fill;
            heap_image[pos] = value;
            heap_fill++;
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (heap_image[pos] >= heap_image[parent]) break;
               tmp = heap_image[pos];
               heap_image[pos] = heap_image[parent];
               heap_image[parent] = tmp;
               pos = parent;
            end
         end
      end else begin
         if (heap_fill == 0) begin
            r.status = mhpq_pkg::STATUS_EMPTY;
         end else begin
            r.min_value = heap_image[0];
            heap_fill--;
            heap_image[0] = heap_image[heap_fill];
            pos = 0;
            while (1) begin
               left = 2 * pos + 1;
               if (left >= heap_fill) break;
               pick = left;
               if (left + 1 < heap_fill && heap_image[left + 1] < heap_image[left])
                  pick = left + 1;
               if (!(heap_image[pick] < heap_image[pos])) break;
               tmp = heap_image[pos];
               heap_image[pos] = heap_image[pick];
               heap_image[pick] = tmp;
               pos = pick;
            end
         end
      end
      r.count = heap_fill[8:0];
      return r;
   endfunction

   function automatic logic signed [31:0] pick_value();
      unique case ($urandom_range(9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return -32'sd1;
         3, 4: return $signed(32'($urandom_range(15))) - 32'sd8;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic pick_func(int extract_pct);
      return ($urandom_range(99) < extract_pct) ? mhpq_pkg::FUNC_EXTRACT
                                                : mhpq_pkg::FUNC_INSERT;
   endfunction

   task automatic send_item(logic func, logic signed [31:0] value, bit typed,
                            heap_result_type typed_result);
      heap_result_type predicted;
      while (!(items_sent >= QUIET_FIRST && items_sent < QUIET_LAST) &&
             $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      predicted = heap_apply(func, value);
      pending_results.push_back(typed ? typed_result : predicted);
      items_sent++;
      if (func == mhpq_pkg::FUNC_INSERT) insert_count++;
      else extract_count++;
      if (predicted.status == mhpq_pkg::STATUS_FULL) full_drops++;
      if (predicted.status == mhpq_pkg::STATUS_EMPTY) empty_extracts++;
      if (heap_fill > peak_fill) peak_fill = heap_fill;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : receiver
      heap_result_type want;
      rsp_ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && responses_seen == HOLD_AT_RESPONSE) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         if (responses_seen >= QUIET_FIRST && responses_seen < QUIET_LAST)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= 33);
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (pending_results.size() == 0) begin
               $error("unexpected result: min_value %0d status %0d count %0d",
                      rsp_min_value, rsp_status, rsp_count);
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_min_value !== want.min_value) begin
                  $error("min_value: expected %0d, got %0d", want.min_value, rsp_min_value);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_count);
                  failures++;
               end
            end
         end
      end
   end

   initial begin : sender
      int i;
      req_valid <= 1'b0;
      req_func <= mhpq_pkg::FUNC_INSERT;
      req_value <= '0;
      heap_fill = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         send_item(directed_rows[i].func, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].result);

      for (i = 0; i < 60; i++)
         send_item(pick_func(40), pick_value(), 1'b0, '0);
      // fill to capacity, then push against the full heap
      while (heap_fill < HEAP_DEPTH)
         send_item(pick_func(10), pick_value(), 1'b0, '0);
      repeat (4) send_item(mhpq_pkg::FUNC_INSERT, pick_value(), 1'b0, '0);
      // drain to empty, then pull from the empty heap
      while (heap_fill > 0)
         send_item(pick_func(90), pick_value(), 1'b0, '0);
      repeat (3) send_item(mhpq_pkg::FUNC_EXTRACT, pick_value(), 1'b0, '0);
      for (i = 0; i < 60; i++)
         send_item(pick_func(35 + $urandom_range(30)), pick_value(), 1'b0, '0);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transfers: %0d inserts, %0d extracts, peak occupancy %0d",
               items_sent, insert_count, extract_count, peak_fill);
      $display("Dropped inserts on full heap: %0d, extracts on empty heap: %0d, failures: %0d",
               full_drops, empty_extracts, failures);
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
